@@ rtl/core/qau_pkg.sv @@
`default_nettype none
package qau_pkg;

    localparam int LANES    = 4;
    localparam int SQ_STEPS = 32;
    localparam int DV_STEPS = 32;
    localparam int SQ_LAT   = SQ_STEPS + 2;
    localparam int DV_LAT   = DV_STEPS + 1;
    localparam int PIPE_LAT = 2 + SQ_LAT + DV_LAT;
    localparam int IN_W     = 296;
    localparam int OUT_W    = 168;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_SCL  = 4'd3,
        OP_SDIV = 4'd4,
        OP_DOT  = 4'd5,
        OP_INV  = 4'd6,
        OP_LEN  = 4'd7,
        OP_NORM = 4'd8
    } op_t;

    typedef logic [LANES-1:0][31:0] quat_t;

    typedef struct packed {
        logic        div_en;
        logic        neg;
        logic [32:0] val;
    } lane_in_t;

    typedef struct packed {
        op_t                   op;
        logic                  zdiv;
        logic [31:0]           scal;
        lane_in_t [LANES-1:0]  lane;
        logic [64:0]           dvsr;
    } side_t;

    typedef struct packed {
        logic [63:0] xs;
        logic [34:0] rem;
        logic [31:0] root;
        logic        big;
        side_t       side;
    } sq_t;

    typedef struct packed {
        logic        div_en;
        logic        neg;
        logic        ovf;
        logic [31:0] xq;
        logic [66:0] rem;
        logic [66:0] dvsr;
        logic [31:0] direct;
    } dv_t;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -66'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [3:0] neg_mask(input logic [1:0] c);
        logic [3:0] m;
        case (c)
            2'd0:    m = 4'b1110;
            2'd1:    m = 4'b1000;
            2'd2:    m = 4'b0010;
            default: m = 4'b0100;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/qau_mac_lane.sv @@
`default_nettype none
module qau_mac_lane (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire qau_pkg::quat_t            x,
    input  wire qau_pkg::quat_t            y,
    input  wire logic [3:0]                negm,
    output logic signed [65:0]             sum
);
    import qau_pkg::*;

    logic signed [63:0] prod_reg [LANES];
    logic [3:0]         negm_reg;
    logic signed [65:0] sum_reg;
    logic signed [65:0] sum_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < LANES; t++)
            begin
                prod_reg[t] <= $signed(x[t]) * $signed(y[t]);
            end
            negm_reg <= negm;
            sum_reg  <= sum_next;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int t = 0; t < LANES; t++)
        begin
            if (negm_reg[t])
                sum_next = sum_next - 66'(prod_reg[t]);
            else
                sum_next = sum_next + 66'(prod_reg[t]);
        end
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

@@ rtl/core/qau_sqrt.sv @@
`default_nettype none
module qau_sqrt (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [64:0]     lsq,
    input  wire qau_pkg::side_t  side_i,
    output logic [32:0]          len,
    output qau_pkg::side_t       side_o
);
    import qau_pkg::*;

    sq_t         stg_reg [SQ_STEPS+1];
    logic [32:0] len_reg;
    side_t       side_reg;

    function automatic sq_t sq_step(input sq_t s);
        sq_t         n;
        logic [34:0] rs;
        logic [34:0] trial;
        n     = s;
        rs    = {s.rem[32:0], s.xs[63:62]};
        trial = {1'b0, s.root, 2'b01};
        if (rs >= trial)
        begin
            n.rem  = rs - trial;
            n.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            n.rem  = rs;
            n.root = {s.root[30:0], 1'b0};
        end
        n.xs = {s.xs[61:0], 2'b00};
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= '{xs: lsq[63:0], rem: '0, root: '0, big: lsq[64], side: side_i};
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                stg_reg[j+1] <= sq_step(stg_reg[j]);
            end
            if (stg_reg[SQ_STEPS].big)
                len_reg <= 33'h1_0000_0000;
            else
                len_reg <= {1'b0, stg_reg[SQ_STEPS].root}
                           + 33'(stg_reg[SQ_STEPS].rem > {3'b000, stg_reg[SQ_STEPS].root});
            side_reg <= stg_reg[SQ_STEPS].side;
        end
    end

    assign len    = len_reg;
    assign side_o = side_reg;

endmodule
`default_nettype wire

@@ rtl/core/qau_div_lane.sv @@
`default_nettype none
module qau_div_lane (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire qau_pkg::dv_t  d_in,
    output logic [31:0]        res
);
    import qau_pkg::*;

    dv_t         stg_reg [DV_STEPS+1];
    dv_t         last;
    logic [31:0] cap;
    logic [31:0] mag;

    function automatic dv_t dv_step(input dv_t s);
        dv_t         n;
        logic [67:0] r2;
        logic [67:0] r3;
        n  = s;
        r2 = {s.rem, s.xq[31]};
        r3 = r2 - {1'b0, s.dvsr};
        if (r2 >= {1'b0, s.dvsr})
        begin
            n.rem = r3[66:0];
            n.xq  = {s.xq[30:0], 1'b1};
        end
        else
        begin
            n.rem = r2[66:0];
            n.xq  = {s.xq[30:0], 1'b0};
        end
        return n;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= d_in;
            for (int j = 0; j < DV_STEPS; j++)
            begin
                stg_reg[j+1] <= dv_step(stg_reg[j]);
            end
        end
    end

    always_comb
    begin
        last = stg_reg[DV_STEPS];
        cap  = last.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mag  = (last.ovf || last.xq > cap) ? cap : last.xq;
        if (!last.div_en)
            res = last.direct;
        else if (last.neg)
            res = 32'd0 - mag;
        else
            res = mag;
    end

endmodule
`default_nettype wire

@@ rtl/core/quaternion_arithmetic_unit.sv @@
`default_nettype none
// channel  direction  payload (tdata, lowest bit first)
// s_axis   in         operation, a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k, scalar
// m_axis   out        out_r, out_i, out_j, out_k, out_scalar, zero_divide
// One transaction per cycle while the output is not stalled.
// Latency is dominated by the 32-step square root pipeline and the 32-step divider lanes.
// rst_n clears valid bits only; datapath registers are not reset.
// A stalled output freezes the whole pipeline, and s_axis_tready falls with it.
module quaternion_arithmetic_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // operation, a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k, scalar, zero pad
    input  wire logic [qau_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // out_r, out_i, out_j, out_k, out_scalar, zero_divide, zero pad
    output logic [qau_pkg::OUT_W-1:0]        m_axis_tdata
);
    import qau_pkg::*;

    logic                en;
    op_t                 op_in;
    quat_t               a_in;
    quat_t               b_in;
    logic [31:0]         s_in;
    quat_t               y_sel [LANES];
    logic [3:0]          nm_sel [LANES];
    quat_t               as_in;
    logic signed [65:0]  lsum [LANES];

    logic [PIPE_LAT-1:0] vld_reg;
    op_t                 op1_reg, op2_reg;
    quat_t               a1_reg, a2_reg, as1_reg, as2_reg;
    logic [31:0]         s1_reg, s2_reg;

    side_t               side3;
    logic [64:0]         lsq;
    logic [32:0]         sq_len;
    side_t               sq_side;
    dv_t                 dv_in [LANES];
    logic [31:0]         dv_res [LANES];
    logic [31:0]         scal_set;
    logic [DV_LAT-1:0]   zd_reg;
    logic [31:0]         sc_reg [DV_LAT];

    logic                ov_reg;
    logic [OUT_W-1:0]    od_reg;

    assign en            = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign op_in         = op_t'(s_axis_tdata[3:0]);
    assign s_in          = s_axis_tdata[291:260];

    always_comb
    begin
        for (int c = 0; c < LANES; c++)
        begin
            a_in[c] = s_axis_tdata[4 + 32*c +: 32];
            b_in[c] = s_axis_tdata[132 + 32*c +: 32];
            if (op_in == OP_SUB)
                as_in[c] = sat32(66'($signed(a_in[c])) - 66'($signed(b_in[c])));
            else
                as_in[c] = sat32(66'($signed(a_in[c])) + 66'($signed(b_in[c])));
        end
        for (int c = 0; c < LANES; c++)
        begin
            nm_sel[c] = '0;
            for (int t = 0; t < LANES; t++)
            begin
                case (op_in)
                    OP_MUL:                 y_sel[c][t] = b_in[t ^ c];
                    OP_SCL:                 y_sel[c][t] = (t == c) ? s_in : 32'd0;
                    OP_DOT:                 y_sel[c][t] = b_in[t];
                    OP_INV, OP_LEN, OP_NORM: y_sel[c][t] = a_in[t];
                    default:                y_sel[c][t] = 32'd0;
                endcase
            end
            if (op_in == OP_MUL)
                nm_sel[c] = neg_mask(2'(c));
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_mac
        qau_mac_lane u_mac (
            .clk  (clk),
            .en   (en),
            .x    (a_in),
            .y    (y_sel[g]),
            .negm (nm_sel[g]),
            .sum  (lsum[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= op_in;
            a1_reg  <= a_in;
            s1_reg  <= s_in;
            as1_reg <= as_in;
            op2_reg <= op1_reg;
            a2_reg  <= a1_reg;
            s2_reg  <= s1_reg;
            as2_reg <= as1_reg;
        end
    end

    always_comb
    begin
        logic signed [65:0] rt;
        logic [32:0]        mag;
        logic [31:0]        ac;
        lsq        = lsum[0][64:0];
        side3      = '0;
        side3.op   = op2_reg;
        side3.zdiv = ((op2_reg == OP_SDIV) && (s2_reg == 32'd0))
                     || (((op2_reg == OP_INV) || (op2_reg == OP_NORM)) && (lsq == '0));
        rt         = lsum[0] + 66'sd32768;
        side3.scal = (op2_reg == OP_DOT) ? sat32(rt >>> 16) : 32'd0;
        side3.dvsr = (op2_reg == OP_SDIV)
                     ? {33'd0, (s2_reg[31] ? 32'd0 - s2_reg : s2_reg)} : lsq;
        for (int c = 0; c < LANES; c++)
        begin
            ac  = a2_reg[c];
            mag = ac[31] ? 33'd0 - {1'b1, ac} : {1'b0, ac};
            rt  = lsum[c] + 66'sd32768;
            case (op2_reg)
                OP_ADD, OP_SUB:
                    side3.lane[c].val = {1'b0, as2_reg[c]};
                OP_MUL, OP_SCL:
                    side3.lane[c].val = {1'b0, sat32(rt >>> 16)};
                OP_SDIV, OP_INV, OP_NORM:
                begin
                    if (!side3.zdiv)
                    begin
                        side3.lane[c].div_en = 1'b1;
                        side3.lane[c].val    = mag;
                        if (op2_reg == OP_SDIV)
                            side3.lane[c].neg = ac[31] ^ s2_reg[31];
                        else if (op2_reg == OP_INV && c != 0)
                            side3.lane[c].neg = !ac[31] && (ac != 32'd0);
                        else
                            side3.lane[c].neg = ac[31];
                    end
                end
                default:
                    side3.lane[c].val = '0;
            endcase
        end
    end

    qau_sqrt u_sqrt (
        .clk    (clk),
        .en     (en),
        .lsq    (lsq),
        .side_i (side3),
        .len    (sq_len),
        .side_o (sq_side)
    );

    always_comb
    begin
        logic [64:0] d65;
        logic [66:0] num;
        d65 = (sq_side.op == OP_NORM) ? {32'd0, sq_len} : sq_side.dvsr;
        if (sq_side.op == OP_LEN)
            scal_set = (sq_len > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : sq_len[31:0];
        else
            scal_set = sq_side.scal;
        for (int c = 0; c < LANES; c++)
        begin
            if (sq_side.op == OP_INV)
                num = {34'd0, sq_side.lane[c].val} << 33;
            else
                num = {34'd0, sq_side.lane[c].val} << 17;
            num              = num + {2'b00, d65};
            dv_in[c].div_en  = sq_side.lane[c].div_en;
            dv_in[c].neg     = sq_side.lane[c].neg;
            dv_in[c].dvsr    = {1'b0, d65, 1'b0};
            dv_in[c].ovf     = {32'd0, num[66:32]} >= dv_in[c].dvsr;
            dv_in[c].rem     = dv_in[c].ovf ? 67'd0 : {32'd0, num[66:32]};
            dv_in[c].xq      = num[31:0];
            dv_in[c].direct  = sq_side.lane[c].val[31:0];
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_div
        qau_div_lane u_div (
            .clk  (clk),
            .en   (en),
            .d_in (dv_in[g]),
            .res  (dv_res[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zd_reg[0] <= sq_side.zdiv;
            sc_reg[0] <= scal_set;
            for (int j = 1; j < DV_LAT; j++)
            begin
                zd_reg[j] <= zd_reg[j-1];
                sc_reg[j] <= sc_reg[j-1];
            end
            od_reg <= {7'd0, zd_reg[DV_LAT-1], sc_reg[DV_LAT-1],
                       dv_res[3], dv_res[2], dv_res[1], dv_res[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_axis_tvalid};
            ov_reg  <= vld_reg[PIPE_LAT-1];
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

`ifndef SYNTHESIS
    a_zd_quat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[160] |-> m_axis_tdata[127:0] == '0)
        else $error("zero_divide with non-zero quaternion");
    a_zd_scal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[160] |-> m_axis_tdata[159:128] == '0)
        else $error("zero_divide with non-zero scalar");
    a_pipe_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[PIPE_LAT-1] |=> m_axis_tvalid)
        else $error("pipeline result lost before output register");
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");
`endif

endmodule
`default_nettype wire

@@ tb/sv/quaternion_arithmetic_unit_checker.sv @@
`default_nettype none
module quaternion_arithmetic_unit_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    input  wire logic                      s_axis_tready,
    input  wire logic [qau_pkg::IN_W-1:0]  s_axis_tdata,
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    input  wire logic [qau_pkg::OUT_W-1:0] m_axis_tdata,
    output int                             failures,
    output int                             pending
);
    import qau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q_MIN = -128'sd2147483648;
    localparam int PERM [4][4] = '{'{0,1,2,3}, '{1,0,3,2}, '{2,3,0,1}, '{3,2,1,0}};
    localparam int SIGN [4][4] = '{'{1,-1,-1,-1}, '{1,1,1,-1}, '{1,-1,1,1}, '{1,1,-1,1}};

    logic [OUT_W-1:0] expected_results [$];

    function automatic logic [31:0] saturate(input logic signed [127:0] v);
        if (v > Q_MAX)
            return 32'h7FFF_FFFF;
        else if (v < Q_MIN)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] round_q16(input logic signed [127:0] s);
        logic signed [127:0] t;
        t = (s + 128'sd32768) >>> 16;
        return saturate(t);
    endfunction

    function automatic logic [127:0] magnitude(input logic signed [31:0] x);
        logic signed [127:0] w;
        w = x;
        return (w < 0) ? -w : w;
    endfunction

    function automatic logic [31:0] round_quotient(input logic [127:0] mag, input int k,
                                                   input bit neg, input logic [127:0] d);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] cap;
        logic [31:0]  v;
        num = (mag << (k + 1)) + d;
        q   = num / (d << 1);
        cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        v   = (q > cap) ? cap[31:0] : q[31:0];
        return neg ? -v : v;
    endfunction

    function automatic logic [127:0] norm_sq(input logic signed [31:0] a [4]);
        logic signed [127:0] s;
        logic signed [127:0] w;
        s = 0;
        for (int c = 0; c < 4; c++)
        begin
            w = a[c];
            s += w * w;
        end
        return s;
    endfunction

    function automatic logic [127:0] rounded_root(input logic [127:0] l);
        logic [127:0] r;
        logic [127:0] t;
        if (l >= (128'd1 << 64))
            return 128'd1 << 32;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (t * t <= l)
                r = t;
        end
        return (l - r * r > r) ? r + 1 : r;
    endfunction

    function automatic logic [OUT_W-1:0] quaternion_result(input logic [IN_W-1:0] d);
        logic [3:0]          op;
        logic signed [31:0]  a [4];
        logic signed [31:0]  b [4];
        logic signed [31:0]  s;
        logic [31:0]         q [4];
        logic [31:0]         sc;
        logic                zd;
        logic signed [127:0] acc;
        logic signed [127:0] x;
        logic signed [127:0] y;
        logic [127:0]        l;
        logic [127:0]        len;
        op = d[3:0];
        for (int c = 0; c < 4; c++)
        begin
            a[c] = d[4 + 32*c +: 32];
            b[c] = d[132 + 32*c +: 32];
            q[c] = 0;
        end
        s  = d[260 +: 32];
        sc = 0;
        zd = 0;
        case (op)
            OP_ADD, OP_SUB:
                for (int c = 0; c < 4; c++)
                begin
                    x = a[c];
                    y = b[c];
                    q[c] = saturate(op == OP_ADD ? x + y : x - y);
                end
            OP_MUL:
                for (int c = 0; c < 4; c++)
                begin
                    acc = 0;
                    for (int t = 0; t < 4; t++)
                    begin
                        x = a[t];
                        y = b[PERM[c][t]];
                        acc = (SIGN[c][t] < 0) ? acc - x * y : acc + x * y;
                    end
                    q[c] = round_q16(acc);
                end
            OP_SCL:
                for (int c = 0; c < 4; c++)
                begin
                    x = a[c];
                    y = s;
                    q[c] = round_q16(x * y);
                end
            OP_SDIV:
                if (s == 0)
                    zd = 1;
                else
                    for (int c = 0; c < 4; c++)
                        q[c] = round_quotient(magnitude(a[c]), 16, (a[c] < 0) != (s < 0),
                                              magnitude(s));
            OP_DOT:
            begin
                acc = 0;
                for (int t = 0; t < 4; t++)
                begin
                    x = a[t];
                    y = b[t];
                    acc += x * y;
                end
                sc = round_q16(acc);
            end
            OP_INV:
            begin
                l = norm_sq(a);
                if (l == 0)
                    zd = 1;
                else
                    for (int c = 0; c < 4; c++)
                        q[c] = round_quotient(magnitude(a[c]), 32,
                                              c == 0 ? a[c] < 0 : a[c] > 0, l);
            end
            OP_LEN:
            begin
                len = rounded_root(norm_sq(a));
                sc  = (len > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : len[31:0];
            end
            OP_NORM:
            begin
                len = rounded_root(norm_sq(a));
                if (len == 0)
                    zd = 1;
                else
                    for (int c = 0; c < 4; c++)
                        q[c] = round_quotient(magnitude(a[c]), 16, a[c] < 0, len);
            end
            default: ;
        endcase
        return {7'd0, zd, sc, q[3], q[2], q[1], q[0]};
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            failures++;
        end
    endtask

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    always @(posedge clk)
    begin
        logic [OUT_W-1:0] e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transaction on m_axis: %h", m_axis_tdata);
                failures++;
            end
            else
            begin
                e = expected_results.pop_front();
                compare_field("out_r", e[31:0], m_axis_tdata[31:0]);
                compare_field("out_i", e[63:32], m_axis_tdata[63:32]);
                compare_field("out_j", e[95:64], m_axis_tdata[95:64]);
                compare_field("out_k", e[127:96], m_axis_tdata[127:96]);
                compare_field("out_scalar", e[159:128], m_axis_tdata[159:128]);
                compare_field("zero_divide", {31'd0, e[160]}, {31'd0, m_axis_tdata[160]});
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_results.push_back(quaternion_result(s_axis_tdata));
        pending = expected_results.size();
    end
endmodule
`default_nettype wire

@@ tb/sv/quaternion_arithmetic_unit_tb.sv @@
`default_nettype none
module quaternion_arithmetic_unit_tb;
    import qau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS      = 1400;
    localparam int CYCLE_CAP  = 200000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    int               failures;
    int               pending;
    int               cycles;
    int               received;
    bit               quiet;
    bit               held_off;

    quaternion_arithmetic_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    quaternion_arithmetic_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .failures      (failures),
        .pending       (pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            4:       return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            5:
                case ($urandom_range(0, 5))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return ONE;
                    3:       return -ONE;
                    4:       return 32'hFFFF_FFFF;
                    default: return 32'd1;
                endcase
            6:       return $urandom_range(0, 8) - 4;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] pack_item(input logic [3:0] op,
                                                  input logic [31:0] ar, ai, aj, ak,
                                                  input logic [31:0] br, bi, bj, bk,
                                                  input logic [31:0] s);
        return {4'd0, s, bk, bj, bi, br, ak, aj, ai, ar, op};
    endfunction

    task automatic send_item(input logic [IN_W-1:0] item);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        received      = 0;
        held_off      = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 4);
            if (!held_off && received == 200)
            begin
                held_off = 1;
                stall    = 300;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            received++;
            @(negedge clk);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [3:0]  op;
        logic [31:0] av [4];
        logic [31:0] bv [4];
        logic [31:0] s;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(pack_item(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, ONE, 0,
                            32'h7FFF_FFFF, 32'h8000_0000, -ONE, 5, 0));
        send_item(pack_item(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, ONE, 0,
                            32'h8000_0000, 32'h7FFF_FFFF, ONE, 5, 0));
        send_item(pack_item(OP_MUL, ONE, 2*ONE, 3*ONE, 4*ONE, -ONE, ONE, -2*ONE, ONE, 0));
        send_item(pack_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 0));
        send_item(pack_item(OP_SCL, 32'h8000_0000, 32'h7FFF_FFFF, ONE, 32'h0000_8000,
                            0, 0, 0, 0, 32'h8000_0000));
        send_item(pack_item(OP_SCL, 1, -1, ONE, 32'hFFFF_8000, 0, 0, 0, 0, 32'h0000_8000));
        send_item(pack_item(OP_SDIV, ONE, -ONE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_SDIV, ONE, -ONE, 32'h7FFF_FFFF, 32'h8000_0000,
                            0, 0, 0, 0, 1));
        send_item(pack_item(OP_SDIV, 3, -3, 32'h7FFF_FFFF, 32'h8000_0000,
                            0, 0, 0, 0, 32'h8000_0000));
        send_item(pack_item(OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 0));
        send_item(pack_item(OP_DOT, ONE, 2*ONE, 3*ONE, 4*ONE, ONE, -ONE, ONE, -ONE, 0));
        send_item(pack_item(OP_INV, 0, 0, 0, 0, 1, 2, 3, 4, 7));
        send_item(pack_item(OP_INV, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_INV, ONE, -ONE, ONE, -ONE, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_INV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_LEN, 0, 0, 0, 0, 9, 9, 9, 9, 9));
        send_item(pack_item(OP_LEN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_LEN, 3*ONE, 4*ONE, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 0, 0, 0, 0, 0));
        send_item(pack_item(OP_NORM, 3*ONE, -4*ONE, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_item(4'd9, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        send_item(pack_item(4'd15, '1, '1, '1, '1, '1, '1, '1, '1, '1));

        for (int n = 0; n < ITEMS; n++)
        begin
            if (n % 200 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(OP_ADD, OP_NORM));
            for (int c = 0; c < 4; c++)
            begin
                av[c] = pick_value();
                bv[c] = pick_value();
            end
            if ($urandom_range(0, 19) == 0)
                av = '{0, 0, 0, 0};
            s = pick_value();
            send_item(pack_item(op, av[0], av[1], av[2], av[3],
                                bv[0], bv[1], bv[2], bv[3], s));
        end
        s_axis_tvalid <= 1'b0;
        quiet = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
